// File: hw/rtl/wbps_pkg.sv
package wbps_pkg;

	// Pattern storage is fixed by the register layout: two 64-bit words.
	localparam int PATTERN_STORE   = 16;
	localparam int DEF_MAX_PATTERN = 16;

	localparam int ADDR_W    = 64;
	localparam int WORD_W    = 64;
	localparam int CARE_W    = 16;
	localparam int LEN_W     = 5;
	localparam int POS_W     = 32;
	localparam int CFG_IDX_W = 3;

	// Result queue depth; a request may leave two results.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LOW  = 3'd0,
		CFG_PATTERN_HIGH = 3'd1,
		CFG_CARE_MASK    = 3'd2,
		CFG_PATTERN_LEN  = 3'd3,
		CFG_FIND_ALL     = 3'd4,
		CFG_BASE_ADDRESS = 3'd5
	} cfg_idx_t;

	// What one accepted byte produced, handed from the matcher to the queue.
	typedef struct packed {
		logic             match;
		logic             term;
		logic             match_last;
		logic [POS_W-1:0] offset;
	} hit_t;

	typedef struct packed {
		logic [ADDR_W-1:0] match_address;
		logic              found;
		logic              last;
	} result_t;

endpackage

// File: hw/rtl/wbps_if.sv
interface wbps_in_if import wbps_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] match_address;
	logic              found;
	logic              last;

	modport source (output valid, output match_address, output found, output last,
		input ready);
	modport sink (input valid, input match_address, input found, input last,
		output ready);
endinterface

interface wbps_cfg_if import wbps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [WORD_W-1:0]    wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// File: hw/rtl/wbps_match.sv
module wbps_match import wbps_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	input  logic [8*PATTERN_STORE-1:0]   pattern,
	input  logic [CARE_W-1:0]            care,
	input  logic [LEN_W-1:0]             plen,
	input  logic                         find_all,
	output hit_t                         hit
);

	localparam int WIN = (MAX_PATTERN < PATTERN_STORE) ? MAX_PATTERN : PATTERN_STORE;

	logic [7:0]       win_q [WIN];
	logic [7:0]       win_next [WIN];
	logic [POS_W-1:0] pos_q;
	logic             done_q;

	logic [LEN_W-1:0] n_used;
	logic [WIN-1:0]   len_ok;
	logic             window_hit;
	logic [POS_W-1:0] count;
	logic             match;
	logic             done_after;
	logic             term;

	always_comb begin
		win_next[0] = data_byte;
		for (int k = 1; k < WIN; k++) begin
			win_next[k] = win_q[k-1];
		end
	end

	always_comb begin
		if (plen == '0) begin
			n_used = LEN_W'(1);
		end else if (plen > LEN_W'(WIN)) begin
			n_used = LEN_W'(WIN);
		end else begin
			n_used = plen;
		end
	end

	// One compare row per possible length; the newest byte lines up with the
	// last pattern byte, so the row for length n compares pattern byte i with
	// the byte received n-1-i requests ago.
	always_comb begin
		for (int n = 1; n <= WIN; n++) begin
			len_ok[n-1] = 1'b1;
			for (int i = 0; i < n; i++) begin
				if (care[i] && (pattern[i*8 +: 8] != win_next[n-1-i])) begin
					len_ok[n-1] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		window_hit = 1'b0;
		for (int n = 1; n <= WIN; n++) begin
			if (n_used == LEN_W'(n)) begin
				window_hit = len_ok[n-1];
			end
		end
	end

	assign count      = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);
	assign match      = !done_q && (count >= POS_W'(n_used)) && window_hit;
	assign done_after = done_q || (match && !find_all);
	assign term       = last_byte && (find_all || !done_after);

	assign hit.match      = match;
	assign hit.term       = term;
	assign hit.match_last = !find_all;
	assign hit.offset     = count - POS_W'(n_used);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN; k++) begin
				win_q[k] <= '0;
			end
			pos_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			for (int k = 0; k < WIN; k++) begin
				win_q[k] <= win_next[k];
			end
			if (last_byte) begin
				pos_q  <= '0;
				done_q <= 1'b0;
			end else begin
				pos_q  <= count;
				done_q <= done_after;
			end
		end
	end

	// A range end always leaves the position and the done flag cleared.
	a_range_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> (pos_q == '0) && !done_q)
		else $error("range state not cleared after final byte");

	// Once the first match is reported, no further match comes in that range.
	a_done_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !hit.match)
		else $error("match reported after search finished");

endmodule

// File: hw/rtl/wbps_outq.sv
module wbps_outq import wbps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  hit_t              hit,
	input  logic [ADDR_W-1:0] base,
	output logic              room,
	wbps_out_if.source        res
);

	result_t            fifo_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q;
	logic [Q_PTR_W-1:0] rptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	result_t            match_entry;
	result_t            end_entry;
	result_t            first_entry;
	logic [1:0]         npush;
	logic               pop;

	assign match_entry.match_address = base + ADDR_W'(hit.offset);
	assign match_entry.found         = 1'b1;
	assign match_entry.last          = hit.match_last;

	assign end_entry.match_address = '0;
	assign end_entry.found         = 1'b0;
	assign end_entry.last          = 1'b1;

	assign first_entry = hit.match ? match_entry : end_entry;
	assign npush       = {1'b0, hit.match} + {1'b0, hit.term};
	assign pop         = res.valid && res.ready;

	// Room for two more results beyond what is queued and what is in flight.
	assign room = (cnt_q + Q_CNT_W'(npush)) <= Q_CNT_W'(Q_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (npush != 2'd0) begin
			fifo_q[wptr_q] <= first_entry;
		end
		if (npush == 2'd2) begin
			fifo_q[wptr_q + Q_PTR_W'(1)] <= end_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + Q_PTR_W'(npush);
			rptr_q <= rptr_q + Q_PTR_W'(pop);
			cnt_q  <= cnt_q + Q_CNT_W'(npush) - Q_CNT_W'(pop);
		end
	end

	assign res.valid         = cnt_q != '0;
	assign res.match_address = fifo_q[rptr_q].match_address;
	assign res.found         = fifo_q[rptr_q].found;
	assign res.last          = fifo_q[rptr_q].last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue overflow");

	// In first-match mode a match closes the range, so no end marker joins it.
	a_first_no_marker: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit.match && hit.match_last && hit.term))
		else $error("end marker after a first-mode match");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == Q_CNT_W'(1)) && pop && (npush == 2'd0) |=> !res.valid)
		else $error("result queue shows data after draining");

endmodule

// File: hw/rtl/wildcard_byte_pattern_scan_top.sv
// Wildcard byte pattern scanner.
//
// The scan channel takes one byte of a memory range per request, in address
// order, with last_byte set on the final byte. Each request on the hits channel
// carries one result, and a byte may cause none, one or two of them: a match
// gives base address plus the offset of the match's first byte with found set;
// the final byte of a range adds an end marker (found clear, address zero,
// last set), which in first-match mode only appears when the range held no
// match. The cfg channel writes the pattern, care mask, pattern length, mode
// and base address; it is always ready and is meant to be written only while
// the scanner is idle.
//
// Throughput is one byte per cycle while the scan channel is ready: the window
// compare, counter and search state update all settle in the cycle the byte
// is accepted. A result passes through the stage register and then the result
// queue before it shows up on the hits channel. A final byte in all-matches
// mode can yield two results, which leave the queue one at a time; a run of
// such bytes fills the queue and makes the scan channel drop ready.
// When the receiver stalls, the four-entry result queue absorbs results and
// the scan channel drops ready once the queue, counting the results held in
// the stage register, has fewer than two free entries.
// Reset clears the byte window, the position count, the queue and all
// registers but the queue storage, with pattern length one.
module wildcard_byte_pattern_scan_top import wbps_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic       clk,
	input  logic       arst_n,
	wbps_cfg_if.sink   cfg,
	wbps_in_if.sink    scan,
	wbps_out_if.source hits
);

	logic [WORD_W-1:0] pat_lo_q;
	logic [WORD_W-1:0] pat_hi_q;
	logic [CARE_W-1:0] care_q;
	logic [LEN_W-1:0]  plen_q;
	logic              find_all_q;
	logic [ADDR_W-1:0] base_q;

	logic              accept;
	logic              room;
	hit_t              hit;
	hit_t              hit_s1;

	// Configuration writes are always accepted; indexes past the list are
	// dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q   <= '0;
			pat_hi_q   <= '0;
			care_q     <= '0;
			plen_q     <= LEN_W'(1);
			find_all_q <= 1'b0;
			base_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.reg_index))
				CFG_PATTERN_LOW:  pat_lo_q   <= cfg.wdata;
				CFG_PATTERN_HIGH: pat_hi_q   <= cfg.wdata;
				CFG_CARE_MASK:    care_q     <= cfg.wdata[CARE_W-1:0];
				CFG_PATTERN_LEN:  plen_q     <= cfg.wdata[LEN_W-1:0];
				CFG_FIND_ALL:     find_all_q <= cfg.wdata[0];
				CFG_BASE_ADDRESS: base_q     <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	// The scan side only waits on queue space, never on the result side
	// being taken in the same cycle.
	assign scan.ready = room;
	assign accept     = scan.valid && scan.ready;

	wbps_match #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (scan.data_byte),
		.last_byte (scan.last_byte),
		.pattern   ({pat_hi_q, pat_lo_q}),
		.care      (care_q),
		.plen      (plen_q),
		.find_all  (find_all_q),
		.hit       (hit)
	);

	// Stage register between the compare and the address add; an empty stage
	// holds no match and no end marker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= '0;
		end else if (accept) begin
			hit_s1 <= hit;
		end else begin
			hit_s1 <= '0;
		end
	end

	wbps_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.hit    (hit_s1),
		.base   (base_q),
		.room   (room),
		.res    (hits)
	);

	// A stalled scan request never leaves anything in the stage register.
	a_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !hit_s1.match && !hit_s1.term)
		else $error("stage register loaded without an accepted byte");

	// In all-matches mode a final byte always produces an end marker.
	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan.last_byte && find_all_q |-> hit.term)
		else $error("final byte produced no end marker");

endmodule

// File: bench/wildcard_byte_pattern_scan_top_tb.sv
`timescale 1ns / 100ps

module wildcard_byte_pattern_scan_top_tb;
	import wbps_pkg::*;

	// The scanner is built with its default window size; the predictor saturates
	// the pattern length against the same value.
	localparam int SCAN_MAX    = DEF_MAX_PATTERN;
	// Generous bound on the whole run, far above the slowest legal run.
	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTE_TARGET = 820;
	// Length of the one long receiver hold-off that forces the result queue full.
	localparam int LONG_HOLD   = 300;

	typedef enum {SINK_FREE, SINK_COIN, SINK_SLOW} sink_mode_t;

	logic clk;
	logic arst_n;

	wbps_cfg_if cfg_bus ();
	wbps_in_if  scan_bus ();
	wbps_out_if hit_bus ();

	wildcard_byte_pattern_scan_top #(
		.MAX_PATTERN(SCAN_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.scan(scan_bus),
		.hits(hit_bus)
	);

	// The scoreboard keeps its own copy of the registers and of the byte window.
	// Each accepted byte is run through the window compare right away, and the
	// results it causes are queued in order; each result from the hits channel
	// is then checked against the oldest one waiting.
	class scan_scoreboard;
		logic [63:0] pat_low;
		logic [63:0] pat_high;
		logic [15:0] care;
		logic [4:0]  plen;
		logic        find_all;
		logic [63:0] base;
		logic [7:0]  window [16];
		logic [31:0] pos;
		logic        done;
		result_t     expected_hits [$];
		int          errors;

		function new();
			pat_low  = '0;
			pat_high = '0;
			care     = '0;
			plen     = 5'd1;
			find_all = 1'b0;
			base     = '0;
			foreach (window[i]) window[i] = 8'h00;
			pos      = '0;
			done     = 1'b0;
			errors   = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [63:0] v);
			case (idx)
				CFG_PATTERN_LOW:  pat_low  = v;
				CFG_PATTERN_HIGH: pat_high = v;
				CFG_CARE_MASK:    care     = v[15:0];
				CFG_PATTERN_LEN:  plen     = v[4:0];
				CFG_FIND_ALL:     find_all = v[0];
				CFG_BASE_ADDRESS: base     = v;
				default: ;
			endcase
		endfunction

		// Zero counts as one; anything beyond the window or the pattern store
		// is clipped to it.
		function int unsigned used_len();
			int unsigned n;
			n = 32'(plen);
			if (n == 0) n = 1;
			if (n > SCAN_MAX) n = SCAN_MAX;
			if (n > PATTERN_STORE) n = PATTERN_STORE;
			return n;
		endfunction

		function logic [7:0] pattern_byte(int unsigned i);
			logic [127:0] both;
			both = {pat_high, pat_low};
			return both[8*i +: 8];
		endfunction

		// Pattern byte i lines up with the byte received n-1-i steps ago.
		function bit window_hit(int unsigned n);
			int unsigned i;
			for (i = 0; i < n; i++) begin
				if (care[i] && pattern_byte(i) != window[n-1-i]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void predict_byte(logic [7:0] d, logic fin);
			int unsigned n;
			int          i;
			logic [31:0] count;
			result_t     r;
			n = used_len();
			for (i = 15; i > 0; i--) window[i] = window[i-1];
			window[0] = d;
			count = (pos == '1) ? pos : pos + 32'd1;
			pos = count;
			if (!done && count >= n && window_hit(n)) begin
				r.match_address = base + {32'd0, count - n[31:0]};
				r.found = 1'b1;
				r.last  = !find_all;
				if (!find_all) done = 1'b1;
				expected_hits = {expected_hits, r};
			end
			if (fin) begin
				if (find_all || !done) begin
					r.match_address = '0;
					r.found = 1'b0;
					r.last  = 1'b1;
					expected_hits = {expected_hits, r};
				end
				pos  = '0;
				done = 1'b0;
			end
		endfunction

		function void check_hit(logic [63:0] addr, logic fnd, logic lst);
			result_t want;
			if (expected_hits.size() == 0) begin
				$display("%0t: result with none expected: address %h found %b last %b",
					$time, addr, fnd, lst);
				errors++;
				return;
			end
			want = expected_hits.pop_front();
			if (addr !== want.match_address) begin
				$display("%0t: match_address expected %h, actual %h",
					$time, want.match_address, addr);
				errors++;
			end
			if (fnd !== want.found) begin
				$display("%0t: found expected %b, actual %b", $time, want.found, fnd);
				errors++;
			end
			if (lst !== want.last) begin
				$display("%0t: last expected %b, actual %b", $time, want.last, lst);
				errors++;
			end
		endfunction
	endclass

	scan_scoreboard scanner = new();

	int bytes_sent         = 0;
	int burst_left         = 0;
	int long_hold_requests = 0;
	int cycle_count        = 0;
	logic [7:0] byte_list [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver. Every result taken at a clock edge is checked against the
	// predictor. Ready then follows a pattern of its own: stretches of full
	// speed, stretches of coin-flip stalls and stretches where it is mostly
	// stalled. When the stimulus asks for it, ready stays low for a long
	// hold-off, counted here, so that the result queue fills and the scanner
	// has to push back on its byte input.
	initial begin : hit_sink
		sink_mode_t mode;
		int mode_left;
		int hold_left;
		int holds_taken;
		mode        = SINK_FREE;
		mode_left   = 0;
		hold_left   = 0;
		holds_taken = 0;
		hit_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hit_bus.valid && hit_bus.ready)
				scanner.check_hit(hit_bus.match_address, hit_bus.found, hit_bus.last);
			if (holds_taken != long_hold_requests) begin
				holds_taken = long_hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				hit_bus.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(3, 0))
						0, 1: mode = SINK_FREE;
						2: mode = SINK_COIN;
						default: mode = SINK_SLOW;
					endcase
					mode_left = $urandom_range(40, 4);
				end
				mode_left--;
				case (mode)
					SINK_FREE: hit_bus.ready <= 1'b1;
					SINK_COIN: hit_bus.ready <= 1'($urandom_range(1, 0));
					default:   hit_bus.ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	// Offer one byte and hold it until the scanner takes it. Valid is left high,
	// so a following byte goes out on the next cycle without a bubble.
	task automatic send_byte(input logic [7:0] d, input logic fin);
		scan_bus.valid     <= 1'b1;
		scan_bus.data_byte <= d;
		scan_bus.last_byte <= fin;
		do @(posedge clk); while (!scan_bus.ready);
		scanner.predict_byte(d, fin);
		bytes_sent++;
	endtask

	// The sender works in bursts: at the end of each burst it drops valid for a
	// random gap (sometimes none) and then picks a new burst length. Long bursts
	// give stretches with no idling at all.
	task automatic offer_byte(input logic [7:0] d, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? $urandom_range(12, 1) : $urandom_range(2, 0);
			if (gap > 0) begin
				scan_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(80, 20)
				: $urandom_range(8, 1);
		end
		burst_left--;
		send_byte(d, fin);
	endtask

	task automatic sender_idle();
		scan_bus.valid <= 1'b0;
		burst_left = 0;
	endtask

	// Registers only change once every expected result is out; the extra cycles
	// cover bytes still in the pipeline that cause no result.
	task automatic wait_drained();
		while (scanner.expected_hits.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Valid stays high across a batch of writes; the caller lowers it.
	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] v);
		cfg_bus.valid     <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.wdata     <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		scanner.set_reg(idx, v);
	endtask

	// Writes every register. The narrow ones carry random junk in the unused
	// upper bits, which the scanner must ignore.
	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
		input logic [15:0] care, input logic [4:0] len, input logic all,
		input logic [63:0] base);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(CFG_PATTERN_LOW, lo);
		write_reg(CFG_PATTERN_HIGH, hi);
		write_reg(CFG_CARE_MASK, {junk[63:16], care});
		write_reg(CFG_PATTERN_LEN, {junk[63:5], len});
		write_reg(CFG_FIND_ALL, {junk[63:1], all});
		write_reg(CFG_BASE_ADDRESS, base);
		cfg_bus.valid <= 1'b0;
	endtask

	// Sends byte_list as one range; with close clear the range stays open.
	task automatic send_list(input bit close);
		int i;
		for (i = 0; i < byte_list.size(); i++)
			offer_byte(byte_list[i], close && i == byte_list.size() - 1);
	endtask

	// A random setting with the extremes of every register mixed in. Pattern
	// lengths are mostly small so that matches are frequent.
	task automatic random_config();
		logic [63:0] lo, hi, base;
		logic [15:0] care;
		logic [4:0]  len;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		if ($urandom_range(7, 0) == 0) lo = '0;
		if ($urandom_range(7, 0) == 0) hi = '1;
		case ($urandom_range(7, 0))
			0: care = '0;
			1: care = '1;
			2: care = 16'($urandom) & 16'($urandom);
			default: care = 16'($urandom) | 16'($urandom);
		endcase
		case ($urandom_range(9, 0))
			0: len = 5'd0;
			1: len = 5'd1;
			2: len = 5'd16;
			3: len = 5'd31;
			4: len = 5'd17;
			default: len = 5'($urandom_range(12, 2));
		endcase
		case ($urandom_range(5, 0))
			0: base = '0;
			1: base = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15, 0));
			default: base = {$urandom, $urandom};
		endcase
		configure(lo, hi, care, len, 1'($urandom_range(1, 0)), base);
	endtask

	// One well-formed range. Most ranges carry a planted copy of the pattern,
	// with random bytes in its wildcard slots; the rest of the range mixes
	// random bytes with pattern bytes, so near misses and extra matches occur.
	task automatic scan_random_range();
		int unsigned n;
		int len, start, j, k;
		bit plant;
		logic [7:0] d;
		n = scanner.used_len();
		len = ($urandom_range(5, 0) == 0) ? $urandom_range(64, 1) : $urandom_range(n + 8, 1);
		plant = ($urandom_range(3, 0) != 0) && (len >= n);
		start = plant ? $urandom_range(len - n, 0) : -1;
		for (j = 0; j < len; j++) begin
			if (plant && j >= start && j < start + n) begin
				k = j - start;
				d = scanner.care[k] ? scanner.pattern_byte(k) : 8'($urandom);
			end else if ($urandom_range(2, 0) == 0) begin
				d = scanner.pattern_byte($urandom_range(n - 1, 0));
			end else begin
				d = 8'($urandom);
			end
			offer_byte(d, j == len - 1);
		end
	endtask

	// Every byte matches a one-byte wildcard pattern, so each byte leaves a
	// result. The receiver holds off for a long stretch meanwhile, and the
	// sender keeps offering back to back until the scanner stalls its input.
	task automatic pressure_phase();
		int j;
		configure({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd1, 1'b1,
			{$urandom, $urandom});
		long_hold_requests++;
		for (j = 0; j < 40; j++) send_byte(8'($urandom), j == 39);
		sender_idle();
		wait_drained();
	endtask

	initial begin : stimulus
		bit pressure_done;
		pressure_done = 1'b0;
		arst_n             <= 1'b0;
		scan_bus.valid     <= 1'b0;
		scan_bus.data_byte <= 8'h00;
		scan_bus.last_byte <= 1'b0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.reg_index  <= CFG_PATTERN_LOW;
		cfg_bus.wdata      <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: a one-byte wildcard in first-match mode matches the
		// first byte, and the rest of the range is ignored with no end marker.
		byte_list = '{8'h00, 8'hFF};
		send_list(1'b1);
		sender_idle();
		wait_drained();

		// Four-byte pattern with a wildcard in slot 2, all-matches mode, and a
		// base address just below the top so the second match wraps around.
		// Care bits above the pattern length are set and must be ignored.
		configure(64'hFFFF_FFFF_EF00_ADDE, 64'h8000_0000_0000_0001, 16'hFFFB, 5'd4, 1'b1,
			64'hFFFF_FFFF_FFFF_FFFE);
		byte_list = '{8'hDE, 8'hAD, 8'h00, 8'hEF, 8'hDE, 8'hAD, 8'h7F, 8'hEF};
		send_list(1'b1);
		sender_idle();
		wait_drained();

		// Full-length pattern against ranges shorter than it, including a range
		// of a single byte: only the end marker comes out.
		configure(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'hFFFF, 5'd16, 1'b0,
			64'h0000_0000_0000_1000);
		byte_list = '{8'hDE, 8'hAD, 8'h01};
		send_list(1'b1);
		byte_list = '{8'h80};
		send_list(1'b1);
		sender_idle();
		wait_drained();

		// Length zero behaves as one. The first byte matches in first-match mode,
		// then the mode flips to all-matches in the middle of the range: no more
		// matches are reported, but the final byte still gives an end marker.
		configure(64'h0000_0000_0000_0055, 64'h0, 16'h0001, 5'd0, 1'b0, 64'h0000_0000_0000_0040);
		byte_list = '{8'h55, 8'h55};
		send_list(1'b0);
		sender_idle();
		wait_drained();
		write_reg(CFG_FIND_ALL, 64'd1);
		cfg_bus.valid <= 1'b0;
		byte_list = '{8'h55};
		send_list(1'b1);
		sender_idle();
		wait_drained();

		// Random phases: a new setting, then a few ranges, then drain. Halfway
		// through, one phase is spent on back pressure.
		while (bytes_sent < BYTE_TARGET) begin
			if (!pressure_done && bytes_sent > BYTE_TARGET / 2) begin
				pressure_phase();
				pressure_done = 1'b1;
			end else begin
				random_config();
				repeat ($urandom_range(4, 1)) scan_random_range();
				sender_idle();
				wait_drained();
			end
		end

		// Every expected result has been taken by now; the tail catches any
		// stray result that should not exist.
		repeat (16) @(posedge clk);
		if (scanner.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_if.sv
hw/rtl/wbps_match.sv
hw/rtl/wbps_outq.sv
hw/rtl/wildcard_byte_pattern_scan_top.sv
bench/wildcard_byte_pattern_scan_top_tb.sv
